[hw/rtl/sdmd_pkg.sv]
// Shared widths, constants and types of the sigma-delta motion detector.
package sdmd_pkg;

    localparam int PIX_W = 8;
    localparam int IDX_W = 17;
    localparam int GAIN_W = 4;
    localparam int WORD_W = 2 * PIX_W;
    localparam int DEFAULT_MAX_PIXELS = 131072;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd4;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic [PIX_W-1:0] variance;
        logic             foreground;
    } sdmd_upd_t;

endpackage

[hw/rtl/sdmd_state_ram.sv]
// Per-pixel mean and variance store with one write port and one registered read port.
module sdmd_state_ram
    import sdmd_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_PIXELS,
    parameter int ADDR_W = $clog2(DEFAULT_MAX_PIXELS)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/sdmd_update.sv]
// Mean and variance update and foreground decision for one pixel.
module sdmd_update
    import sdmd_pkg::*;
(
    input  logic [PIX_W-1:0]  pixel,
    input  logic              init_frame,
    input  logic [GAIN_W-1:0] gain,
    input  logic [PIX_W-1:0]  mean_old,
    input  logic [PIX_W-1:0]  variance_old,
    output sdmd_upd_t         upd
);

    logic [PIX_W-1:0]        mean_new;
    logic [PIX_W-1:0]        delta;
    logic [PIX_W+GAIN_W-1:0] product;
    logic [PIX_W-1:0]        target;
    logic [PIX_W-1:0]        variance_new;

    always_comb
    begin
        if (mean_old < pixel)
        begin
            mean_new = mean_old + 1'b1;
        end
        else if (mean_old > pixel)
        begin
            mean_new = mean_old - 1'b1;
        end
        else
        begin
            mean_new = mean_old;
        end

        delta = (mean_new > pixel) ? (mean_new - pixel) : (pixel - mean_new);
        product = gain * delta;
        target = (product > (PIX_W+GAIN_W)'(PIX_MAX)) ? PIX_MAX : product[PIX_W-1:0];

        variance_new = variance_old;
        if (delta != PIX_ZERO)
        begin
            if (variance_old < target)
            begin
                variance_new = variance_old + 1'b1;
            end
            else if (variance_old > target)
            begin
                variance_new = variance_old - 1'b1;
            end
        end

        if (init_frame)
        begin
            upd.mean = pixel;
            upd.variance = PIX_ZERO;
            upd.foreground = 1'b0;
        end
        else
        begin
            upd.mean = mean_new;
            upd.variance = variance_new;
            upd.foreground = (delta < variance_new);
        end
    end

endmodule

[hw/rtl/sigma_delta_motion_detect.sv]
// Top level of the sigma-delta motion detector: request pipeline, forwarding and output register.
//
// Pixel requests enter on in_valid/in_stall with pixel, pixel_index and init_frame.
// Each request yields exactly one foreground bit on out_valid/out_stall, in order.
// variance_gain is written through cfg_valid/cfg_ready/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. cfg_ready is always high.
// A request has its state read from memory at the edge that accepts it; it is updated
// and written back at the edge where it leaves the update stage, where its result
// enters the output register.
// Throughput is one pixel per cycle while out_stall is low, set by the single read and single
// write port of the state memory, each used once per pixel. A write and a read of the same
// entry at the same edge are resolved by forwarding the written word.
// Indices at or beyond MAX_PIXELS leave the state untouched and give foreground 0.
// Reset clears the pipeline valids and sets the gain to 4; the memory is not cleared,
// so every pixel needs an init frame before it is used.
// When the receiver stalls a valid result, the output register and the stage behind it hold.
// The block holds at most two requests, and in_stall rises in the same cycle as out_stall once
// the update stage and the output register both hold a request; no request is lost or dropped.
module sigma_delta_motion_detect
    import sdmd_pkg::*;
#(
    parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GAIN_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  pixel,
    input  logic [IDX_W-1:0]  pixel_index,
    input  logic              init_frame,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              foreground
);

    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    logic [GAIN_W-1:0] variance_gain_reg;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_in_range_reg;
    logic              s1_init_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    logic              out_valid_reg;
    logic              foreground_reg;

    logic [EXT_W-1:0]  idx_ext;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;
    logic              accept;
    logic              out_free;
    logic              s1_adv;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] state_word;
    sdmd_upd_t         upd;

    assign idx_ext = EXT_W'(pixel_index);
    assign in_addr = idx_ext[ADDR_W-1:0];
    assign in_range = (32'(pixel_index) < 32'(MAX_PIXELS));

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign state_word = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign wr_en = s1_adv && s1_in_range_reg;
    assign wr_data = {upd.mean, upd.variance};

    sdmd_state_ram #(
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    sdmd_update u_update (
        .pixel        (s1_pixel_reg),
        .init_frame   (s1_init_reg),
        .gain         (variance_gain_reg),
        .mean_old     (state_word[WORD_W-1:PIX_W]),
        .variance_old (state_word[PIX_W-1:0]),
        .upd          (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variance_gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            variance_gain_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_addr_reg <= in_addr;
            s1_in_range_reg <= in_range;
            s1_init_reg <= init_frame;
            fwd_hit_reg <= wr_en && (s1_addr_reg == in_addr);
            fwd_data_reg <= wr_data;
        end
        if (s1_adv)
        begin
            foreground_reg <= s1_in_range_reg ? upd.foreground : 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign foreground = foreground_reg;

    a_stall_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a held request in the pipeline");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request missing from the update stage");

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced request missing from the output register");

    a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && wr_en && (s1_addr_reg == in_addr)) |=> fwd_hit_reg)
        else $error("same-entry write and read not forwarded");

endmodule

[test/tb_sigma_delta_motion_detect.sv]
// Self-checking testbench of the sigma-delta motion detector with its own foreground predictor.
module tb_sigma_delta_motion_detect;
    import sdmd_pkg::*;

    localparam int TB_MAX_PIXELS = 98304;
    localparam int IDX_TOP = (1 << IDX_W) - 1;
    localparam int POOL_SIZE = 24;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 320;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic [IDX_W-1:0] idx;
        logic             fg;
    } fg_expect_t;

    class foreground_predictor;
        logic [PIX_W-1:0]  bg_mean [TB_MAX_PIXELS];
        logic [PIX_W-1:0]  bg_var [TB_MAX_PIXELS];
        logic [GAIN_W-1:0] gain;
        fg_expect_t        fg_queue[$];
        int                mismatches;
        int                n_requests;
        int                n_init;
        int                n_beyond;
        int                n_checked;
        int                n_fg;

        function new();
            gain = GAIN_RESET;
            mismatches = 0;
            n_requests = 0;
            n_init = 0;
            n_beyond = 0;
            n_checked = 0;
            n_fg = 0;
        endfunction

        function int pending_count();
            return fg_queue.size();
        endfunction

        function void note_pixel(input logic [PIX_W-1:0] pix, input logic [IDX_W-1:0] idx,
                                 input logic init);
            logic [PIX_W-1:0] m;
            logic [PIX_W-1:0] v;
            logic [PIX_W-1:0] d;
            logic [PIX_W-1:0] tgt;
            int               prod;
            fg_expect_t       e;
            e.pix = pix;
            e.idx = idx;
            e.fg = 1'b0;
            n_requests++;
            if (idx >= TB_MAX_PIXELS) begin
                n_beyond++;
            end
            else if (init) begin
                n_init++;
                bg_mean[idx] = pix;
                bg_var[idx] = PIX_ZERO;
            end
            else begin
                m = bg_mean[idx];
                if (m < pix)
                    m++;
                else if (m > pix)
                    m--;
                d = (m > pix) ? m - pix : pix - m;
                prod = int'(gain) * int'(d);
                tgt = (prod > int'(PIX_MAX)) ? PIX_MAX : prod[PIX_W-1:0];
                v = bg_var[idx];
                if (d != PIX_ZERO) begin
                    if (v < tgt)
                        v++;
                    else if (v > tgt)
                        v--;
                end
                bg_mean[idx] = m;
                bg_var[idx] = v;
                e.fg = (d < v);
            end
            fg_queue.push_back(e);
        endfunction

        task report_mismatch(input string msg);
            $display("tb: mismatch: %s", msg);
            mismatches++;
        endtask

        task check_foreground(input logic fg);
            fg_expect_t e;
            n_checked++;
            if (fg === 1'b1)
                n_fg++;
            if (fg_queue.size() == 0) begin
                report_mismatch($sformatf("foreground %0b with no request pending", fg));
            end
            else begin
                e = fg_queue.pop_front();
                if (fg !== e.fg)
                    report_mismatch($sformatf("pixel %0d index %0d: foreground %0b, expected %0b",
                                              e.pix, e.idx, fg, e.fg));
            end
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [PIX_W-1:0]  pixel = '0;
    logic [IDX_W-1:0]  pixel_index = '0;
    logic              init_frame = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              foreground;

    foreground_predictor fgp = new();

    logic [IDX_W-1:0] live_pool[$];
    logic [IDX_W-1:0] last_live_idx;
    bit               have_last = 1'b0;
    bit               quiet = 1'b0;
    bit               steady_feed = 1'b0;
    bit               hold_request = 1'b0;
    int               stall_left = 0;
    int               n_settings = 0;

    sigma_delta_motion_detect #(
        .MAX_PIXELS(TB_MAX_PIXELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel(pixel),
        .pixel_index(pixel_index),
        .init_frame(init_frame),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .foreground(foreground)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                fgp.check_foreground(foreground);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [IDX_W-1:0] idx,
                              input logic init);
        if (!steady_feed && !quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= pix;
        pixel_index <= idx;
        init_frame <= init;
        do @(posedge clk); while (in_stall);
        fgp.note_pixel(pix, idx, init);
        if (idx < TB_MAX_PIXELS) begin
            last_live_idx = idx;
            have_last = 1'b1;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (fgp.pending_count() != 0)
            @(posedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        cfg_valid <= 1'b1;
        cfg_data <= g;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        fgp.gain = g;
        n_settings++;
    endtask

    task automatic add_live(input logic [IDX_W-1:0] idx);
        if (live_pool.size() < POOL_SIZE)
            live_pool.push_back(idx);
        else
            live_pool[$urandom_range(0, POOL_SIZE - 1)] = idx;
    endtask

    task automatic random_pixel();
        int               r;
        int               k;
        int               p;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] pix;
        logic             init;
        r = $urandom_range(0, 99);
        pix = PIX_W'($urandom);
        if (live_pool.size() == 0 || r < 8) begin
            idx = IDX_W'($urandom_range(0, TB_MAX_PIXELS - 1));
            init = 1'b1;
            add_live(idx);
        end
        else if (r < 12) begin
            idx = IDX_W'($urandom_range(TB_MAX_PIXELS, IDX_TOP));
            init = 1'($urandom_range(0, 1));
        end
        else if (r < 15) begin
            idx = live_pool[$urandom_range(0, live_pool.size() - 1)];
            init = 1'b1;
        end
        else begin
            if (r < 45 && have_last)
                idx = last_live_idx;
            else
                idx = live_pool[$urandom_range(0, live_pool.size() - 1)];
            init = 1'b0;
            k = $urandom_range(0, 99);
            if (k < 60) begin
                p = int'(fgp.bg_mean[idx]) + int'($urandom_range(0, 24)) - 12;
                if (p < 0)
                    p = 0;
                if (p > 255)
                    p = 255;
                pix = p[PIX_W-1:0];
            end
            else if (k >= 85) begin
                pix = fgp.bg_mean[idx];
            end
        end
        send_pixel(pix, idx, init);
    endtask

    task automatic run_phase(input logic [GAIN_W-1:0] g, input bit with_hold);
        int i;
        wait_drained();
        write_gain(g);
        if (with_hold)
            hold_request = 1'b1;
        for (i = 0; i < PHASE_ITEMS; i++) begin
            steady_feed = with_hold && i < 100;
            random_pixel();
        end
        steady_feed = 1'b0;
    endtask

    initial
    begin
        int i;
        int waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gain first: loads, both saturation ends, delta zero and out-of-range indices.
        send_pixel(8'd0, 17'd0, 1'b1);
        send_pixel(8'd255, IDX_W'(TB_MAX_PIXELS - 1), 1'b1);
        send_pixel(8'd128, 17'd65537, 1'b1);
        send_pixel(8'd170, 17'd12345, 1'b1);
        send_pixel(8'd100, 17'd7, 1'b1);
        live_pool = '{17'd0, IDX_W'(TB_MAX_PIXELS - 1), 17'd65537, 17'd12345, 17'd7};
        send_pixel(8'd255, 17'd0, 1'b0);
        send_pixel(8'd255, 17'd0, 1'b0);
        send_pixel(8'd0, IDX_W'(TB_MAX_PIXELS - 1), 1'b0);
        send_pixel(8'd255, IDX_W'(TB_MAX_PIXELS - 1), 1'b0);
        send_pixel(8'd170, 17'd12345, 1'b0);
        send_pixel(8'd77, IDX_W'(TB_MAX_PIXELS), 1'b1);
        send_pixel(8'd0, IDX_W'(IDX_TOP), 1'b0);
        send_pixel(8'd255, IDX_W'(TB_MAX_PIXELS), 1'b0);
        for (i = 0; i < 7; i++)
            send_pixel(8'd110, 17'd7, 1'b0);
        send_pixel(8'd0, 17'd65537, 1'b0);

        run_phase(4'd15, 1'b1);
        run_phase(4'd1, 1'b0);
        run_phase(4'd0, 1'b0);
        run_phase(GAIN_W'($urandom_range(1, 15)), 1'b0);
        run_phase(GAIN_W'($urandom_range(0, 15)), 1'b0);
        quiet = 1'b1;
        run_phase(4'd8, 1'b0);

        in_valid <= 1'b0;
        waited = 0;
        while (fgp.pending_count() != 0 && waited < 1000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (fgp.pending_count() != 0)
            fgp.report_mismatch($sformatf("%0d results never arrived", fgp.pending_count()));

        $display("tb: %0d pixel requests, %0d init frames, %0d out-of-range indices, %0d gains",
                 fgp.n_requests, fgp.n_init, fgp.n_beyond, n_settings + 1);
        $display("tb: %0d results checked, %0d foreground", fgp.n_checked, fgp.n_fg);
        if (fgp.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sdmd_pkg.sv
hw/rtl/sdmd_state_ram.sv
hw/rtl/sdmd_update.sv
hw/rtl/sigma_delta_motion_detect.sv
test/tb_sigma_delta_motion_detect.sv
